@@ design/ipv4f_pkg.sv @@
// Shared types, constants and octet formatting for the IPv4 dotted-decimal formatter.
package ipv4f_pkg;

	localparam int CHARS_PER_BEAT = 8;
	localparam int BEAT_W         = 8 * CHARS_PER_BEAT;
	localparam int TEXT_W         = 2 * BEAT_W;
	localparam int FIELD_W        = 32;
	localparam int OCTETS         = 4;
	localparam int FIFO_DEPTH     = 2;
	localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_DOT  = 8'h2E;
	localparam logic [3:0] BEAT_CHARS = 4'(CHARS_PER_BEAT);

	typedef struct packed {
		logic [FIELD_W-1:0] chars;
		logic [2:0]         flen;
	} field_t;

	typedef struct packed {
		logic [OCTETS-1:0][FIELD_W-1:0] fields;
		logic [3:0]                     off1;
		logic [3:0]                     off2;
		logic [3:0]                     off3;
		logic [3:0]                     total;
	} entry_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		digit_char = ASCII_ZERO + {4'b0000, d};
	endfunction

	function automatic field_t octet_field(input logic [7:0] v, input logic tail);
		field_t     f;
		logic [3:0] h;
		logic [6:0] r;
		logic [3:0] t;
		logic [6:0] tens;
		logic [3:0] o;
		logic [1:0] n;
		logic [7:0] dot_b;
		h = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
		r = 7'(v - ((v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0)));
		t = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (r >= 7'(10 * i)) begin
				t = 4'(i);
			end
		end
		tens = 7'({3'b000, t} * 7'd10);
		o = 4'(r - tens);
		n = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
		dot_b = tail ? 8'h00 : ASCII_DOT;
		case (n)
			2'd3: begin
				f.chars = {dot_b, digit_char(o), digit_char(t), digit_char(h)};
			end
			2'd2: begin
				f.chars = {8'h00, dot_b, digit_char(o), digit_char(t)};
			end
			default: begin
				f.chars = {16'h0000, dot_b, digit_char(o)};
			end
		endcase
		f.flen = {1'b0, n} + (tail ? 3'd0 : 3'd1);
		octet_field = f;
	endfunction

endpackage

@@ design/ipv4f_front.sv @@
// Front stage: accept an address, format each octet and work out the text layout.
module ipv4f_front import ipv4f_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] address_word,
	input  logic        fifo_full,
	output logic        fifo_push,
	output entry_t      fifo_data
);

	logic   valid_s1;
	entry_t entry_s1;
	entry_t entry_d;
	field_t fld [OCTETS];
	logic   accept;

	always_comb begin
		for (int k = 0; k < OCTETS; k++) begin
			fld[k] = octet_field(address_word[8*k +: 8], k == OCTETS - 1);
			entry_d.fields[k] = fld[k].chars;
		end
		entry_d.off1  = {1'b0, fld[0].flen};
		entry_d.off2  = entry_d.off1 + {1'b0, fld[1].flen};
		entry_d.off3  = entry_d.off2 + {1'b0, fld[2].flen};
		entry_d.total = entry_d.off3 + {1'b0, fld[3].flen};
	end

	assign full      = valid_s1 && fifo_full;
	assign accept    = push && !full;
	assign fifo_push = valid_s1 && !fifo_full;
	assign fifo_data = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fifo_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

@@ design/ipv4f_fifo.sv @@
// Short register queue between the front and back stages.
module ipv4f_fifo import ipv4f_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output entry_t rd_data,
	output logic   empty
);

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_wr;
	logic                  do_rd;

	function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
		ptr_next = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = count_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/ipv4f_back.sv @@
// Back stage: assemble the text and hand it out as one or two beats.
module ipv4f_back import ipv4f_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fifo_empty,
	output logic              fifo_pop,
	input  entry_t            fifo_data,
	output logic              empty,
	input  logic              pop,
	output logic [BEAT_W-1:0] text_chunk,
	output logic [3:0]        char_count,
	output logic              is_last
);

	logic              out_valid_q;
	logic              pend_q;
	logic [BEAT_W-1:0] chunk_q;
	logic [3:0]        count_q;
	logic              last_q;
	logic [BEAT_W-1:0] rest_q;
	logic [3:0]        rest_cnt_q;
	logic [TEXT_W-1:0] text_buf;
	logic              out_free;
	logic              load_rest;
	logic              long_text;

	always_comb begin
		text_buf = {{(TEXT_W-FIELD_W){1'b0}}, fifo_data.fields[0]}
			| ({{(TEXT_W-FIELD_W){1'b0}}, fifo_data.fields[1]} << {fifo_data.off1, 3'b000})
			| ({{(TEXT_W-FIELD_W){1'b0}}, fifo_data.fields[2]} << {fifo_data.off2, 3'b000})
			| ({{(TEXT_W-FIELD_W){1'b0}}, fifo_data.fields[3]} << {fifo_data.off3, 3'b000});
	end

	assign long_text = fifo_data.total > BEAT_CHARS;
	assign out_free  = !out_valid_q || pop;
	assign load_rest = pend_q && out_free;
	assign fifo_pop  = !pend_q && out_free && !fifo_empty;

	assign empty      = !out_valid_q;
	assign text_chunk = chunk_q;
	assign char_count = count_q;
	assign is_last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			out_valid_q <= load_rest || fifo_pop || (out_valid_q && !pop);
			if (load_rest) begin
				pend_q <= 1'b0;
			end else if (fifo_pop) begin
				pend_q <= long_text;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_rest) begin
			chunk_q <= rest_q;
			count_q <= rest_cnt_q;
			last_q  <= 1'b1;
		end else if (fifo_pop) begin
			chunk_q    <= text_buf[BEAT_W-1:0];
			count_q    <= long_text ? BEAT_CHARS : fifo_data.total;
			last_q     <= !long_text;
			rest_q     <= text_buf[TEXT_W-1:BEAT_W];
			rest_cnt_q <= fifo_data.total - BEAT_CHARS;
		end
	end

endmodule

@@ design/ipv4_dotted_decimal_formatter.sv @@
// Top level of the IPv4 dotted-decimal formatter.
// Input channel: push with address_word (first octet in bits 7:0); the beat is
// taken when push is high and full is low.
// Result channel: while empty is low, text_chunk, char_count and is_last show the
// oldest beat; it is taken when pop is high. Text of up to eight characters
// leaves as one beat with is_last set; nine to fifteen characters leave as a
// full beat of eight and then a last beat with the rest. Unused bytes are zero.
// Path: an address is registered in the front stage, written to the queue and
// then loaded into the result register; the second beat replaces the first at
// the edge that pops it.
// Throughput: one beat per cycle at the result register while pop stays high, so
// one address per cycle for short text; long text gives two beats per address.
// A two-entry queue parts the formatting front from the beat back end; when the
// receiver holds pop low the back end holds its beat, the queue fills and full
// rises once the front register is also occupied.
// Reset clears all valid state: empty is high and full is low afterward.
module ipv4_dotted_decimal_formatter import ipv4f_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [31:0]       address_word,
	output logic              empty,
	input  logic              pop,
	output logic [BEAT_W-1:0] text_chunk,
	output logic [3:0]        char_count,
	output logic              is_last
);

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;
	entry_t q_wdata;
	entry_t q_rdata;

	ipv4f_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.address_word (address_word),
		.fifo_full    (q_full),
		.fifo_push    (q_push),
		.fifo_data    (q_wdata)
	);

	ipv4f_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	ipv4f_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (q_empty),
		.fifo_pop   (q_pop),
		.fifo_data  (q_rdata),
		.empty      (empty),
		.pop        (pop),
		.text_chunk (text_chunk),
		.char_count (char_count),
		.is_last    (is_last)
	);

endmodule

@@ design/ipv4f_checker.sv @@
// Port-level checker for the IPv4 dotted-decimal formatter, with its bind.
module ipv4f_checker import ipv4f_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input logic [BEAT_W-1:0] text_chunk,
	input logic [3:0]        char_count,
	input logic              is_last
);

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(text_chunk) && $stable(char_count)
			&& $stable(is_last)))
		else $error("stalled beat changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (char_count != 4'd0 && char_count <= BEAT_CHARS))
		else $error("char_count out of range");

	a_first_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_last) |-> (char_count == BEAT_CHARS))
		else $error("non-last beat not full");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && char_count < BEAT_CHARS)
			|-> ((text_chunk >> {char_count, 3'b000}) == '0))
		else $error("unused bytes not zero");

endmodule

bind ipv4_dotted_decimal_formatter ipv4f_checker u_chk (.*);
